### sv/crc8f_pkg.sv
// Shared types, constants and the CRC-8 step function for the CRC-8
// length-prefixed frame receiver. No dependencies.
package crc8f_pkg;

  // Payload store depth and its address width.
  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned STORE_AW    = $clog2(MAX_PAYLOAD);

  // Reset value of the CRC polynomial register.
  localparam logic [7:0] CRC_POLY_RST = 8'h07;

  // Input operation codes.
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Frame phase; unused codes behave like PH_ADDR.
  typedef enum logic [2:0] {
    PH_ADDR = 3'd0,
    PH_ID   = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OPEN = 3'd0,
    ST_OK   = 3'd1,
    ST_BAD  = 3'd2,
    ST_OVER = 3'd3,
    ST_READ = 3'd4
  } status_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } item_t;

  // One result item as held in the output register.
  typedef struct packed {
    status_t    frame_status;
    logic [7:0] device_address;
    logic [7:0] message_id;
    logic [7:0] payload_length;
    logic [7:0] read_data;
  } result_t;

  // Payload store write request.
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

  // One byte through the MSB-first CRC-8 register, no final xor.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### sv/crc8f_if.sv
// Valid/ready channel interfaces for the frame receiver's input and
// result transactions. Depends on nothing.
interface crc8f_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic [5:0] read_index;

  modport source (output valid, output op, output rx_byte, output read_index,
                  input ready);
  modport sink (input valid, input op, input rx_byte, input read_index,
                output ready);
endinterface

interface crc8f_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_status;
  logic [7:0] device_address;
  logic [7:0] message_id;
  logic [7:0] payload_length;
  logic [7:0] read_data;

  modport source (output valid, output frame_status, output device_address,
                  output message_id, output payload_length, output read_data,
                  input ready);
  modport sink (input valid, input frame_status, input device_address,
                input message_id, input payload_length, input read_data,
                output ready);
endinterface

### sv/crc8f_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module crc8f_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/crc8f_parser.sv
// Frame phase state machine, header registers, running CRC and result
// formation for one item per step. Depends on crc8f_pkg.
module crc8f_parser
  import crc8f_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] crc_poly,
  input  logic [7:0] store_rdata,
  output store_wr_t  store_wr,
  output result_t    res
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_plus;
  logic [7:0] crc_base;
  logic [7:0] crc_upd;
  logic       byte_step;

  assign byte_step = step && (item.op == OP_BYTE);
  assign cnt_plus  = cnt_r + 8'd1;

  // An address byte starts a fresh CRC from zero.
  always_comb begin
    case (phase_r)
      PH_ID, PH_LEN, PH_DATA, PH_CRC: crc_base = crc_r;
      default:                        crc_base = 8'h00;
    endcase
  end

  assign crc_upd = crc8_update(crc_base, item.rx_byte, crc_poly);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (byte_step) begin
      case (phase_r)
        PH_ID:   phase_nxt = PH_LEN;
        PH_LEN:  phase_nxt = (item.rx_byte == 8'h00) ? PH_CRC : PH_DATA;
        PH_DATA: phase_nxt = (cnt_plus == len_r) ? PH_CRC : PH_DATA;
        PH_CRC:  phase_nxt = PH_ADDR;
        default: phase_nxt = PH_ID;
      endcase
    end
  end

  // Datapath updates, store write and result.
  always_comb begin
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    addr_nxt = addr_r;
    id_nxt   = id_r;
    len_nxt  = len_r;
    store_wr = '0;
    res      = '0;
    res.frame_status = ST_OPEN;
    if (item.op == OP_READ) begin
      res.frame_status = ST_READ;
      if ((8'(item.read_index) < len_r) && (8'(item.read_index) < 8'(MAX_PAYLOAD))) begin
        res.read_data = store_rdata;
      end
    end else begin
      case (phase_r)
        PH_ID: begin
          id_nxt  = item.rx_byte;
          crc_nxt = crc_upd;
        end
        PH_LEN: begin
          len_nxt = item.rx_byte;
          crc_nxt = crc_upd;
          cnt_nxt = 8'd0;
        end
        PH_DATA: begin
          // Bytes past the end of the store still count and enter the CRC.
          store_wr.we   = step && (cnt_r < 8'(MAX_PAYLOAD));
          store_wr.addr = cnt_r[STORE_AW-1:0];
          store_wr.data = item.rx_byte;
          crc_nxt       = crc_upd;
          cnt_nxt       = cnt_plus;
        end
        PH_CRC: begin
          if (len_r > 8'(MAX_PAYLOAD)) begin
            res.frame_status = ST_OVER;
          end else if (item.rx_byte == crc_r) begin
            res.frame_status = ST_OK;
          end else begin
            res.frame_status = ST_BAD;
          end
          crc_nxt = 8'h00;
          cnt_nxt = 8'd0;
        end
        default: begin
          addr_nxt = item.rx_byte;
          crc_nxt  = crc_upd;
          cnt_nxt  = 8'd0;
        end
      endcase
    end
    res.device_address = addr_nxt;
    res.message_id     = id_nxt;
    res.payload_length = len_nxt;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ADDR;
      cnt_r   <= 8'd0;
      crc_r   <= 8'h00;
      addr_r  <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 8'd0;
    end else if (byte_step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      addr_r  <= addr_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
    end
  end

  // The CRC byte is expected only after exactly len payload bytes.
  a_crc_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CRC |-> cnt_r == len_r)
    else $error("CRC phase reached with payload count not equal to length");

  // The store is written only by a payload byte inside the store range.
  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    store_wr.we |-> byte_step && phase_r == PH_DATA && cnt_r < 8'(MAX_PAYLOAD))
    else $error("payload store written outside the payload phase");

  // A frame verdict only comes from the CRC byte.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (res.frame_status == ST_OK || res.frame_status == ST_BAD ||
     res.frame_status == ST_OVER) |-> item.op == OP_BYTE && phase_r == PH_CRC)
    else $error("frame verdict outside the CRC phase");

endmodule

### sv/crc8_length_frame_receiver_unit.sv
// Top level of the CRC-8 length-prefixed frame receiver: input register,
// output register, payload store and parser. Depends on crc8f_pkg,
// crc8f_if, crc8f_ram and crc8f_parser.
//
// Usage:
//   in_ch carries one transaction per received byte (op 0, rx_byte) or per
//   payload read (op 1, read_index). out_ch returns one result transaction
//   per input transaction, in order. cfg_we/cfg_wdata write the CRC
//   polynomial; write it only while no transaction is in flight.
// Timing:
//   A transaction is registered in the input register on acceptance and is
//   processed, with its result registered in the output register, once that
//   register is free. One transaction per cycle is sustained while out_ch.ready
//   stays high, since the CRC step and phase update are combinational.
// Reset:
//   rst_n (synchronous, active low) empties both registers, clears the parser
//   state and header, and sets the polynomial to 0x07; the store is kept.
// Backpressure:
//   While out_ch.ready is low the output register holds, at most one more
//   transaction enters the input register, and then in_ch.ready drops.
module crc8_length_frame_receiver_unit
  import crc8f_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  crc8f_in_if.sink          in_ch,
  crc8f_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  logic       s1_v_r;
  item_t      s1_item_r;
  logic       out_v_r;
  result_t    out_res_r;
  logic [7:0] crc_poly_r;
  logic       byp_hit_r;
  logic [7:0] byp_data_r;
  logic       advance;
  logic       accept;
  logic [7:0] ram_rdata;
  logic [7:0] rd_byte;
  store_wr_t  store_wr;
  result_t    res;

  // Handshake: the stage advances when the output register is free.
  assign advance      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || advance;
  assign accept       = in_ch.valid && in_ch.ready;

  // Polynomial register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r <= CRC_POLY_RST;
    end else if (cfg_we) begin
      crc_poly_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.op         <= in_ch.op;
      s1_item_r.rx_byte    <= in_ch.rx_byte;
      s1_item_r.read_index <= in_ch.read_index;
    end
  end

  // A payload byte written in the cycle a read is accepted is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (accept) begin
      byp_hit_r <= store_wr.we && (store_wr.addr == STORE_AW'(in_ch.read_index));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_data_r <= store_wr.data;
    end
  end

  assign rd_byte = byp_hit_r ? byp_data_r : ram_rdata;

  // Payload store.
  crc8f_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (store_wr.we),
    .waddr (store_wr.addr),
    .wdata (store_wr.data),
    .re    (accept),
    .raddr (STORE_AW'(in_ch.read_index)),
    .rdata (ram_rdata)
  );

  // Frame parser.
  crc8f_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .item        (s1_item_r),
    .crc_poly    (crc_poly_r),
    .store_rdata (rd_byte),
    .store_wr    (store_wr),
    .res         (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.frame_status   = out_res_r.frame_status;
  assign out_ch.device_address = out_res_r.device_address;
  assign out_ch.message_id     = out_res_r.message_id;
  assign out_ch.payload_length = out_res_r.payload_length;
  assign out_ch.read_data      = out_res_r.read_data;

  // An accepted transaction always occupies the input register next cycle.
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted transaction lost before processing");

  // A processed transaction always yields a pending result next cycle.
  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("processed transaction produced no result");

  // A stalled result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |-> !advance)
    else $error("stalled result overwritten");

  // A store write only happens while a transaction is being processed.
  a_write_step: assert property (@(posedge clk) disable iff (!rst_n)
    store_wr.we |-> advance)
    else $error("payload store written without a transaction in process");

endmodule
